[hdl/pavs_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the packed array value search block.
// No dependencies; every other file of the block imports this package.
package pavs_pkg;

    localparam int unsigned WordBits     = 64;
    localparam int unsigned WordIdxBits  = 6;
    localparam int unsigned LaneCount    = 64;
    localparam int unsigned LaneIdxBits  = 6;
    localparam int unsigned WidthBits    = 6;
    localparam int unsigned PatBits      = 63;
    localparam int unsigned CountBits    = 21;
    localparam int unsigned IndexBits    = 20;
    localparam int unsigned OffBits      = 12;
    localparam int unsigned ElemVecBits  = LaneCount + 1;
    localparam int unsigned ElemCntBits  = 7;
    localparam int unsigned CfgIdxBits   = 2;
    localparam int unsigned CfgDataBits  = 63;
    localparam int unsigned MaxElements  = 1048576;

    localparam logic [CountBits-1:0] SeenMax = {CountBits{1'b1}};

    localparam logic [CfgIdxBits-1:0] CFG_WIDTH   = 2'd0;
    localparam logic [CfgIdxBits-1:0] CFG_PATTERN = 2'd1;
    localparam logic [CfgIdxBits-1:0] CFG_COUNT   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LANE,
        ST_MERGE
    } t_state;

    typedef struct packed {
        logic valid;
        logic match;
    } t_lane_res;

    typedef struct packed {
        logic go;
        logic last;
    } t_merge_cmd;

endpackage

[hdl/pavs_ifs.sv]
`timescale 1ns / 1ps
// Handshake channels of the packed array value search block: word input,
// result output and configuration write. Depends on pavs_pkg.
interface pavs_in_if import pavs_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [WordBits-1:0] data_word;
    logic                last_word;

    modport source(output valid, data_word, last_word, input ready);
    modport sink(input valid, data_word, last_word, output ready);
endinterface

interface pavs_out_if import pavs_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [IndexBits-1:0] match_index;

    modport source(output valid, found, match_index, input ready);
    modport sink(input valid, found, match_index, output ready);
endinterface

interface pavs_cfg_if import pavs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CfgIdxBits-1:0]  index;
    logic [CfgDataBits-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

[hdl/pavs_lane.sv]
`timescale 1ns / 1ps
// One comparison lane: extracts the element at its own bit offset of a word
// and compares it with the pattern. Depends on pavs_pkg.
module pavs_lane import pavs_pkg::*; (
    input  logic [WordBits-1:0]    i_word,
    input  logic [LaneIdxBits-1:0] i_lane,
    input  logic [WidthBits-1:0]   i_width,
    input  logic [WidthBits-1:0]   i_base,
    input  logic [PatBits-1:0]     i_mask,
    input  logic [PatBits-1:0]     i_pattern,
    output t_lane_res              o_res,
    output logic [PatBits-1:0]     o_rest
);

    logic [OffBits-1:0]  off;
    logic [OffBits-1:0]  fin;
    logic [WordBits-1:0] shifted;

    assign off = OffBits'(i_lane) * OffBits'(i_width) + OffBits'(i_base);
    assign fin = off + OffBits'(i_width);

    assign shifted = (off < OffBits'(WordBits)) ? (i_word >> off[WordIdxBits-1:0])
                                                : '0;

    // The element is only real if it ends inside the word.
    assign o_res.valid = (fin <= OffBits'(WordBits));
    assign o_res.match = ((shifted[PatBits-1:0] & i_mask) == i_pattern);
    assign o_rest      = shifted[PatBits-1:0];

endmodule

[hdl/pavs_merge.sv]
`timescale 1ns / 1ps
// Merging stage: picks the first qualifying match among the lanes, keeps the
// running element count and the first hit of the search. Depends on pavs_pkg.
module pavs_merge import pavs_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_merge_cmd             i_cmd,
    input  logic [ElemVecBits-1:0] i_vld,
    input  logic [ElemVecBits-1:0] i_match,
    input  logic [ElemCntBits-1:0] i_nelem,
    input  logic [CountBits-1:0]   i_count,
    output logic                   o_found,
    output logic [IndexBits-1:0]   o_index
);

    logic [CountBits-1:0]   r_seen;
    logic [CountBits-1:0]   n_seen;
    logic                   r_hit;
    logic                   n_hit;
    logic [IndexBits-1:0]   r_hit_idx;
    logic [IndexBits-1:0]   n_hit_idx;

    logic [CountBits-1:0]   limit;
    logic [CountBits-1:0]   rem;
    logic [ElemVecBits-1:0] qual;
    logic                   any_hit;
    logic [ElemCntBits-1:0] first;
    logic [CountBits:0]     seen_sum;

    // Elements at or beyond the smaller of the count and the array limit
    // are padding and never match.
    assign limit = (i_count < CountBits'(MaxElements)) ? i_count : CountBits'(MaxElements);
    assign rem   = (r_seen < limit) ? (limit - r_seen) : '0;

    always_comb begin
        for (int j = 0; j < ElemVecBits; j++) begin
            qual[j] = i_vld[j] & i_match[j] & (CountBits'(j) < rem);
        end
    end

    always_comb begin
        any_hit = 1'b0;
        first   = '0;
        for (int j = ElemVecBits - 1; j >= 0; j--) begin
            if (qual[j]) begin
                any_hit = 1'b1;
                first   = ElemCntBits'(j);
            end
        end
    end

    assign seen_sum  = (CountBits + 1)'(r_seen) + (CountBits + 1)'(i_nelem);
    assign n_seen    = (seen_sum > (CountBits + 1)'(SeenMax)) ? SeenMax
                                                             : seen_sum[CountBits-1:0];
    assign n_hit     = r_hit | any_hit;
    assign n_hit_idx = r_hit ? r_hit_idx
                             : (any_hit ? IndexBits'(r_seen + CountBits'(first)) : '0);

    assign o_found = n_hit;
    assign o_index = n_hit ? n_hit_idx : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_hit     <= 1'b0;
            r_hit_idx <= '0;
        end else if (i_cmd.go) begin
            if (i_cmd.last) begin
                r_seen    <= '0;
                r_hit     <= 1'b0;
                r_hit_idx <= '0;
            end else begin
                r_seen    <= n_seen;
                r_hit     <= n_hit;
                r_hit_idx <= n_hit_idx;
            end
        end
    end

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.go && i_cmd.last) |=> (r_seen == '0 && !r_hit && r_hit_idx == '0))
        else $error("search state not cleared after the last item");

    a_hit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hit && !(i_cmd.go && i_cmd.last)) |=> r_hit)
        else $error("hit flag dropped within a search");

    a_hit_below_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> (CountBits'(r_hit_idx) < r_seen))
        else $error("hit index not below the number of elements seen");

    a_seen_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.go |=> $stable(r_seen))
        else $error("element count moved without a merge step");

endmodule

[hdl/packed_array_value_search_core.sv]
`timescale 1ns / 1ps
// Top level of the packed array value search block: configuration registers,
// carry register, 64 comparison lanes and the merging stage.
// Depends on pavs_pkg, pavs_ifs, pavs_lane and pavs_merge.
//
// Usage: 64-bit words of a bit-packed array enter on i_in, least significant
// element first; last_word marks the final word of an array. Element width,
// search value and element count are written on i_cfg (index 0, 1, 2); the
// user must write them only while the block is idle, which the block itself
// does not enforce; i_cfg is always ready. All elements of a word are
// compared at once in 64 lanes, and the partial element at the top of a
// word is kept in a carry register for the next word. Each word passes through
// capture, lane compare with carry update and merge. A new word is accepted
// only once the previous one has been merged, one word at a time, because
// each word's parse offset follows from the carry the previous word left.
// On the last word the merge step registers one result item for o_res and
// clears the search state for the next array. The result sits in an output
// register; the next array's words are taken while it waits, and only a
// second last word stalls until o_res drains. Synchronous active-low reset
// clears the search state and restores width 8, value 0 and count 1.
module packed_array_value_search_core import pavs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pavs_in_if.sink     i_in,
    pavs_out_if.source  o_res,
    pavs_cfg_if.sink    i_cfg
);

    t_state r_state;
    t_state n_state;

    logic [WidthBits-1:0]   r_width;
    logic [PatBits-1:0]     r_pattern;
    logic [CountBits-1:0]   r_count;

    logic [PatBits-1:0]     r_carry_bits;
    logic [PatBits-1:0]     n_carry_bits;
    logic [WidthBits-1:0]   r_carry_cnt;
    logic [WidthBits-1:0]   n_carry_cnt;

    logic [WordBits-1:0]    r_word;
    logic                   r_last;
    logic [ElemVecBits-1:0] r_vld;
    logic [ElemVecBits-1:0] n_vld;
    logic [ElemVecBits-1:0] r_match;
    logic [ElemVecBits-1:0] n_match;
    logic [ElemCntBits-1:0] r_nelem;
    logic [ElemCntBits-1:0] n_nelem;

    logic                   r_out_valid;
    logic                   r_found;
    logic [IndexBits-1:0]   r_index;

    logic                   in_ready;
    logic                   lane_load;
    t_merge_cmd             merge_cmd;
    logic                   merge_found;
    logic [IndexBits-1:0]   merge_index;

    logic [WidthBits-1:0]   w_eff;
    logic [PatBits-1:0]     mask;
    logic [PatBits-1:0]     pattern;
    logic                   has_carry;
    logic                   carry_short;
    logic [WidthBits-1:0]   need;
    logic [PatBits-1:0]     low_bits;
    logic [PatBits-1:0]     carry_elem;
    logic                   carry_match;
    logic [WidthBits-1:0]   base;

    t_lane_res              lane_res  [LaneCount];
    logic [PatBits-1:0]     lane_rest [LaneCount];
    logic [LaneCount-1:0]   lane_vld;
    logic [LaneCount-1:0]   lane_match;
    logic [ElemCntBits-1:0] n_lanes;
    logic [PatBits-1:0]     rest_sel;
    logic [OffBits-1:0]     fin_pos;

    // A width of zero behaves as width one.
    assign w_eff   = (r_width == '0) ? WidthBits'(1) : r_width;
    assign mask    = ~({PatBits{1'b1}} << w_eff);
    assign pattern = r_pattern & mask;

    // Element held over from the previous word, completed from this word
    // when it is shorter than the current width.
    assign has_carry   = (r_carry_cnt != '0);
    assign carry_short = has_carry && (r_carry_cnt < w_eff);
    assign need        = w_eff - r_carry_cnt;
    assign low_bits    = r_word[PatBits-1:0] & ~({PatBits{1'b1}} << need);
    assign carry_elem  = carry_short ? ((r_carry_bits | (low_bits << r_carry_cnt)) & mask)
                                     : (r_carry_bits & mask);
    assign carry_match = (carry_elem == pattern);
    assign base        = carry_short ? need : '0;

    for (genvar k = 0; k < LaneCount; k++) begin : g_lane
        pavs_lane u_lane (
            .i_word    (r_word),
            .i_lane    (LaneIdxBits'(k)),
            .i_width   (w_eff),
            .i_base    (base),
            .i_mask    (mask),
            .i_pattern (pattern),
            .o_res     (lane_res[k]),
            .o_rest    (lane_rest[k])
        );
        assign lane_vld[k]   = lane_res[k].valid;
        assign lane_match[k] = lane_res[k].match;
    end

    // Valid lanes form a run from lane 0; the lane just past the run starts
    // exactly where the leftover bits begin.
    always_comb begin
        n_lanes = '0;
        for (int k = 0; k < LaneCount; k++) begin
            if (lane_vld[k]) begin
                n_lanes = ElemCntBits'(k + 1);
            end
        end
    end

    always_comb begin
        rest_sel = '0;
        for (int k = 0; k < LaneCount; k++) begin
            if (n_lanes == ElemCntBits'(k)) begin
                rest_sel = lane_rest[k];
            end
        end
    end

    assign fin_pos = OffBits'(base) + OffBits'(n_lanes) * OffBits'(w_eff);

    always_comb begin
        if (fin_pos < OffBits'(WordBits)) begin
            n_carry_cnt  = WidthBits'(OffBits'(WordBits) - fin_pos);
            n_carry_bits = rest_sel;
        end else begin
            n_carry_cnt  = '0;
            n_carry_bits = '0;
        end
    end

    always_comb begin
        if (has_carry) begin
            n_vld   = {lane_vld, 1'b1};
            n_match = {lane_match, carry_match};
            n_nelem = n_lanes + ElemCntBits'(1);
        end else begin
            n_vld   = {1'b0, lane_vld};
            n_match = {1'b0, lane_match};
            n_nelem = n_lanes;
        end
    end

    pavs_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (merge_cmd),
        .i_vld   (r_vld),
        .i_match (r_match),
        .i_nelem (r_nelem),
        .i_count (r_count),
        .o_found (merge_found),
        .o_index (merge_index)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_LANE;
                end
            end
            ST_LANE: begin
                n_state = ST_MERGE;
            end
            ST_MERGE: begin
                if (merge_cmd.go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs. A last item waits in the merge step while an earlier
    // result is still held in the output register.
    always_comb begin
        in_ready       = 1'b0;
        lane_load      = 1'b0;
        merge_cmd.go   = 1'b0;
        merge_cmd.last = r_last;
        case (r_state)
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_LANE: begin
                lane_load = 1'b1;
            end
            ST_MERGE: begin
                merge_cmd.go = !r_last || !r_out_valid || o_res.ready;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign i_in.ready        = in_ready;
    assign i_cfg.ready       = 1'b1;
    assign o_res.valid       = r_out_valid;
    assign o_res.found       = r_found;
    assign o_res.match_index = r_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_width      <= WidthBits'(8);
            r_pattern    <= '0;
            r_count      <= CountBits'(1);
            r_carry_bits <= '0;
            r_carry_cnt  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_WIDTH:   r_width   <= i_cfg.data[WidthBits-1:0];
                    CFG_PATTERN: r_pattern <= i_cfg.data[PatBits-1:0];
                    CFG_COUNT:   r_count   <= i_cfg.data[CountBits-1:0];
                    default: begin
                    end
                endcase
            end
            if (lane_load) begin
                if (r_last) begin
                    r_carry_bits <= '0;
                    r_carry_cnt  <= '0;
                end else begin
                    r_carry_bits <= n_carry_bits;
                    r_carry_cnt  <= n_carry_cnt;
                end
            end
            if (merge_cmd.go && r_last) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_word <= i_in.data_word;
            r_last <= i_in.last_word;
        end
        if (lane_load) begin
            r_vld   <= n_vld;
            r_match <= n_match;
            r_nelem <= n_nelem;
        end
        if (merge_cmd.go && r_last) begin
            r_found <= merge_found;
            r_index <= merge_index;
        end
    end

    a_carry_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_carry_bits >> r_carry_cnt) == '0))
        else $error("carry register holds bits above its count");

    a_last_clears_carry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LANE && r_last) |=> (r_carry_cnt == '0 && r_carry_bits == '0))
        else $error("carry not cleared after the last item");

    a_out_from_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_MERGE && r_last))
        else $error("result raised without a merge of a last item");

endmodule

[tb/sv/packed_array_value_search_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for packed_array_value_search_core: directed and random packed
// arrays against a first-match scoreboard. Depends on pavs_pkg, pavs_ifs and the core RTL.
module packed_array_value_search_core_tb;
    import pavs_pkg::*;

    localparam int unsigned CycleLimit   = 3_000_000;
    localparam int unsigned HoldCycles   = 400;
    localparam int unsigned SettleCycles = 8;
    localparam int unsigned RandomWords  = 1900;
    localparam logic [CfgIdxBits-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic                 found;
        logic [IndexBits-1:0] index;
    } t_search_result;

    class first_match_scoreboard;
        logic [WidthBits-1:0] width_reg;
        logic [PatBits-1:0]   pattern_reg;
        logic [CountBits-1:0] count_reg;
        logic [PatBits-1:0]   tail_bits;
        logic [WidthBits-1:0] tail_len;
        logic [CountBits-1:0] elem_index;
        logic                 hit_seen;
        logic [IndexBits-1:0] hit_pos;
        t_search_result       expected_hits[$];
        int unsigned          errors, words, results, hits, writes;

        function new();
            width_reg   = 6'd8;
            pattern_reg = '0;
            count_reg   = 21'd1;
            clear_search();
        endfunction

        function void clear_search();
            tail_bits  = '0;
            tail_len   = '0;
            elem_index = '0;
            hit_seen   = 1'b0;
            hit_pos    = '0;
        endfunction

        function void set_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] d);
            writes++;
            case (idx)
                CFG_WIDTH:   width_reg = d[WidthBits-1:0];
                CFG_PATTERN: pattern_reg = d;
                CFG_COUNT:   count_reg = d[CountBits-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_hits.size();
        endfunction

        // Elements past the configured count or the index limit never match.
        function void compare_element(logic [63:0] elem, logic [63:0] pat);
            if (!hit_seen && elem_index < count_reg && elem_index < MaxElements
                    && elem == pat) begin
                hit_seen = 1'b1;
                hit_pos  = elem_index[IndexBits-1:0];
            end
            if (elem_index != SeenMax) elem_index++;
        endfunction

        function void scan_word(logic [WordBits-1:0] word, logic last);
            int unsigned w, p, need;
            logic [63:0] mask, pat, low;
            t_search_result r;
            w    = (width_reg == 0) ? 1 : width_reg;
            mask = (64'd1 << w) - 64'd1;
            pat  = {1'b0, pattern_reg} & mask;
            p    = 0;
            words++;
            if (tail_len != 0) begin
                if (tail_len < w) begin
                    need = w - tail_len;
                    low  = word & ((64'd1 << need) - 64'd1);
                    compare_element(({1'b0, tail_bits} | (low << tail_len)) & mask, pat);
                    p = need;
                end else begin
                    // A width lowered mid-array: surplus carried bits are dropped.
                    compare_element({1'b0, tail_bits} & mask, pat);
                end
            end
            while (p + w <= 64) begin
                compare_element((word >> p) & mask, pat);
                p += w;
            end
            if (p < 64) begin
                tail_bits = PatBits'(word >> p);
                tail_len  = WidthBits'(64 - p);
            end else begin
                tail_bits = '0;
                tail_len  = '0;
            end
            if (last) begin
                r.found = hit_seen;
                r.index = hit_seen ? hit_pos : '0;
                expected_hits.push_back(r);
                clear_search();
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("ERROR at %0t: %s", $time, msg);
        endtask

        task check_result(logic found, logic [IndexBits-1:0] idx);
            t_search_result want;
            results++;
            if (expected_hits.size() == 0) begin
                report($sformatf("result found=%0b index=%0d with nothing expected",
                                 found, idx));
                return;
            end
            want = expected_hits.pop_front();
            if (want.found) hits++;
            if (found !== want.found)
                report($sformatf("found %0b, expected %0b", found, want.found));
            if (idx !== want.index)
                report($sformatf("match_index %0d, expected %0d", idx, want.index));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    pavs_in_if  in_if();
    pavs_out_if res_if();
    pavs_cfg_if cfg_if();

    packed_array_value_search_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_res  (res_if),
        .i_cfg  (cfg_if)
    );

    first_match_scoreboard sb;
    logic [WordBits-1:0]   pack_buf[];
    logic [WidthBits-1:0]  cur_width;
    logic [PatBits-1:0]    cur_pattern;
    bit                    gaps_on;
    bit                    stall_request;
    int unsigned           burst_left;
    int unsigned           words_sent;
    int unsigned           cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("packed_array_value_search_core: mismatch");
            $finish;
        end
    end

    // Results are checked before new words are noted, so an item leaving on the same
    // edge as a last word arrives is matched with the older expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) sb.set_reg(cfg_if.index, cfg_if.data);
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.found, res_if.match_index);
            if (in_if.valid && in_if.ready) sb.scan_word(in_if.data_word, in_if.last_word);
        end
    end

    initial begin : receiver
        int unsigned mode;
        int unsigned tick;
        mode = 0;
        tick = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (stall_request) begin
                stall_request = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HoldCycles) @(negedge i_clk);
            end
            if (tick % 64 == 0) mode = $urandom_range(0, 3);
            case (mode)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= 1'($urandom_range(0, 1));
                2: res_if.ready <= (tick % 5 != 0) && (tick % 7 != 3);
                default: res_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic int unsigned elem_bits(logic [WidthBits-1:0] r);
        return (r == 0) ? 1 : r;
    endfunction

    function automatic void plant(int unsigned j, int unsigned w, logic [63:0] val);
        int unsigned pos;
        for (int unsigned b = 0; b < w; b++) begin
            pos = j * w + b;
            pack_buf[pos / 64][pos[5:0]] = val[b];
        end
    endfunction

    // Random words; optionally every whole element differs from the pattern, and
    // optionally one element is set to it.
    function automatic void build_array(int unsigned n, int unsigned w, logic [63:0] pat,
                                        bit quiet, bit seed_hit);
        int unsigned total;
        pack_buf = new[n];
        foreach (pack_buf[k]) pack_buf[k] = {$urandom(), $urandom()};
        total = (n * 64) / w;
        if (quiet) for (int unsigned j = 0; j < total; j++) plant(j, w, pat ^ 64'd1);
        if (seed_hit) plant($urandom_range(0, total - 1), w, pat);
    endfunction

    task automatic send_word(input logic [WordBits-1:0] d, input logic last);
        if (gaps_on && burst_left == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        in_if.valid     <= 1'b1;
        in_if.data_word <= d;
        in_if.last_word <= last;
        do @(posedge i_clk); while (!in_if.ready);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_array(input int unsigned n);
        for (int unsigned k = 0; k < n; k++) send_word(pack_buf[k], k == n - 1);
    endtask

    // Bits above the register field are filled with noise, which the block ignores.
    task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                             input logic [CfgDataBits-1:0] value);
        logic [CfgDataBits-1:0] d;
        d = CfgDataBits'({$urandom(), $urandom()});
        case (idx)
            CFG_WIDTH: begin
                d[WidthBits-1:0] = value[WidthBits-1:0];
                cur_width = value[WidthBits-1:0];
            end
            CFG_PATTERN: begin
                d = value;
                cur_pattern = value;
            end
            CFG_COUNT: d[CountBits-1:0] = value[CountBits-1:0];
            default: ;
        endcase
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        do @(posedge i_clk); while (!cfg_if.ready);
        @(negedge i_clk);
    endtask

    task automatic end_writes();
        cfg_if.valid <= 1'b0;
    endtask

    // Words that end no array give no result, so a few cycles are allowed after the
    // last expected item before the block counts as idle.
    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [WordBits-1:0] ones;
        logic [WordBits-1:0] w0;
        logic [63:0]         mask;
        logic [63:0]         pat;
        int unsigned         w;
        int unsigned         n;
        int unsigned         random_start;
        bit                  hold_done;
        bit                  first;

        sb              = new();
        ones            = '1;
        cur_width       = 6'd8;
        cur_pattern     = '0;
        gaps_on         = 1'b1;
        burst_left      = 0;
        words_sent      = 0;
        cycle_count     = 0;
        stall_request   = 1'b0;
        hold_done       = 1'b0;
        first           = 1'b1;
        in_if.valid     = 1'b0;
        in_if.data_word = '0;
        in_if.last_word = 1'b0;
        cfg_if.valid    = 1'b0;
        cfg_if.index    = CFG_WIDTH;
        cfg_if.data     = '0;
        i_rst_n         = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: width 8, value 0, one valid element.
        send_word('0, 1'b1);
        send_word(ones, 1'b1);

        // Widest elements, including one that straddles two words.
        wait_idle();
        write_reg(CFG_WIDTH, 63'd63);
        write_reg(CFG_PATTERN, '1);
        write_reg(CFG_COUNT, 63'(SeenMax));
        end_writes();
        send_word(ones, 1'b0);
        send_word(ones, 1'b0);
        send_word(ones, 1'b1);
        send_word('0, 1'b0);
        send_word(ones, 1'b0);
        send_word(ones, 1'b1);

        // A width of zero behaves as one bit.
        wait_idle();
        write_reg(CFG_WIDTH, 63'd0);
        write_reg(CFG_PATTERN, 63'd1);
        write_reg(CFG_COUNT, 63'd64);
        end_writes();
        send_word(64'd1 << 40, 1'b1);
        send_word('0, 1'b1);
        send_word(64'd1 << 63, 1'b1);

        // A count of zero leaves nothing that can match.
        wait_idle();
        write_reg(CFG_WIDTH, 63'd1);
        write_reg(CFG_PATTERN, 63'd0);
        write_reg(CFG_COUNT, 63'd0);
        end_writes();
        send_word('0, 1'b1);

        // Five-bit elements: a match across the word boundary, then one in the padding.
        wait_idle();
        write_reg(CFG_WIDTH, 63'd5);
        write_reg(CFG_PATTERN, 63'h13);
        write_reg(CFG_COUNT, 63'd20);
        end_writes();
        build_array(2, 5, 64'h13, 1'b1, 1'b0);
        plant(12, 5, 64'h13);
        send_array(2);
        build_array(2, 5, 64'h13, 1'b1, 1'b0);
        plant(22, 5, 64'h13);
        send_array(2);

        // Width lowered mid-array while four bits are carried; the spare index is
        // written too and must change nothing.
        wait_idle();
        write_reg(CFG_WIDTH, 63'd60);
        write_reg(CFG_PATTERN, 63'd5);
        write_reg(CFG_COUNT, 63'(SeenMax));
        write_reg(CFG_SPARE, '0);
        end_writes();
        w0 = {$urandom(), $urandom()};
        w0[63:59] = 5'b11011;
        send_word(w0, 1'b0);
        wait_idle();
        write_reg(CFG_WIDTH, 63'd3);
        end_writes();
        send_word({$urandom(), $urandom()}, 1'b1);

        random_start = words_sent;
        while (words_sent - random_start < RandomWords) begin
            wait_idle();
            if (first || $urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 5))
                    0: write_reg(CFG_WIDTH, 63'($urandom_range(0, 3)));
                    1: write_reg(CFG_WIDTH, 63'($urandom_range(60, 63)));
                    2: write_reg(CFG_WIDTH, 63'(8 << $urandom_range(0, 2)));
                    default: write_reg(CFG_WIDTH, 63'($urandom_range(1, 63)));
                endcase
            end
            if (first || $urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 5))
                    0: write_reg(CFG_PATTERN, '0);
                    1: write_reg(CFG_PATTERN, '1);
                    default: write_reg(CFG_PATTERN, 63'({$urandom(), $urandom()}));
                endcase
            end
            if (first || $urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 7))
                    0: write_reg(CFG_COUNT, 63'd0);
                    1: write_reg(CFG_COUNT, 63'd1);
                    2: write_reg(CFG_COUNT, 63'(SeenMax));
                    3: write_reg(CFG_COUNT, 63'(MaxElements));
                    4: write_reg(CFG_COUNT, 63'($urandom()));
                    default: write_reg(CFG_COUNT, 63'($urandom_range(1, 300)));
                endcase
            end
            if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE, 63'({$urandom(), $urandom()}));
            end_writes();
            first   = 1'b0;
            gaps_on = ($urandom_range(0, 3) != 0);
            w       = elem_bits(cur_width);
            mask    = (64'd1 << w) - 64'd1;
            pat     = {1'b0, cur_pattern} & mask;

            // Once, the result side holds off while one-word arrays keep coming, so the
            // output register fills and the input stalls.
            if (!hold_done && words_sent - random_start >= RandomWords / 3) begin
                hold_done     = 1'b1;
                stall_request = 1'b1;
                gaps_on       = 1'b0;
                for (int unsigned k = 0; k < 30; k++) begin
                    build_array(1, w, pat, 1'b0, 1'($urandom_range(0, 1)));
                    send_array(1);
                end
            end

            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 19))
                    0:       n = $urandom_range(13, 40);
                    1, 2, 3: n = $urandom_range(5, 12);
                    default: n = $urandom_range(1, 4);
                endcase
                if ($urandom_range(0, 7) == 0)
                    build_array(n, w, pat, 1'b0, 1'b0);
                else
                    build_array(n, w, pat, 1'($urandom_range(0, 1)),
                                $urandom_range(0, 9) < 7);
                send_array(n);
            end
        end

        wait_idle();
        $display("Checked %0d words, %0d search results (%0d with a match), %0d register writes.",
                 sb.words, sb.results, sb.hits, sb.writes);
        $display("Covered widths 0 to 63, counts 0 to maximum, a mid-array width change,");
        $display("matches in the padding and a long result-side hold-off.");
        if (sb.errors == 0) begin
            $display("packed_array_value_search_core: match");
        end else begin
            $display("packed_array_value_search_core: mismatch");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/pavs_pkg.sv
hdl/pavs_ifs.sv
hdl/pavs_lane.sv
hdl/pavs_merge.sv
hdl/packed_array_value_search_core.sv
tb/sv/packed_array_value_search_core_tb.sv
